@@ rtl/ojc_pkg.sv @@
// Package: shared types and constants of the odometry jump corrector.
package ojc_pkg;
	localparam int FRAC_BITS = 16;
	localparam logic [15:0] MIN_SAMPLES_RESET = 16'd100;
	localparam logic [7:0] SIGMA_LIMIT_RESET = 8'd10;
	localparam logic [0:0] REG_MIN_SAMPLES = 1'b0;
	localparam logic [0:0] REG_SIGMA_LIMIT = 1'b1;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIFF,
		OP_SQ_X,
		OP_SQ_Y,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_TRAVEL,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_VAR,
		OP_TEST,
		OP_COMMIT
	} op_t;

	typedef struct packed {
		op_t  op;
		logic sel_var;   // square-root result: variance root (1) or distance (0)
		logic sel_sq;    // division dividend: square sum (1) or error sum (0)
	} cmd_t;

	typedef struct packed {
		logic have_prev;
		logic moving;      // distance nonzero
		logic test_on;     // sample_count > min_samples
		logic var_pos;
		logic step_done;   // iterative unit finished
	} sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sd2147483647) return 32'sh7fffffff;
		if (v < -34'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage

@@ rtl/ojc_if.sv @@
// Interfaces: valid/ready channels for samples and results.
interface ojc_in_if (input logic clk);
	logic        valid;
	logic        ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] speed;
	logic [47:0] stamp;
	modport source (output valid, pos_x, pos_y, speed, stamp, input ready);
	modport sink (input valid, pos_x, pos_y, speed, stamp, output ready);
endinterface

interface ojc_out_if (input logic clk);
	logic        valid;
	logic        ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic        glitch;
	modport source (output valid, out_x, out_y, glitch, input ready);
	modport sink (input valid, out_x, out_y, glitch, output ready);
endinterface

@@ rtl/ojc_datapath.sv @@
// Datapath: position, error model, shared square-root and divider units.
module ojc_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  ojc_pkg::cmd_t      cmd,
	output ojc_pkg::sts_t      sts,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] speed,
	input  logic [47:0]        stamp,
	input  logic [15:0]        min_samples,
	input  logic [7:0]         sigma_limit,
	output logic signed [31:0] res_x,
	output logic signed [31:0] res_y,
	output logic               res_glitch
);
	logic signed [31:0] px_q, py_q, spd_q;
	logic [47:0]        stamp_q;
	logic signed [31:0] off_x_q, off_y_q, prev_x_q, prev_y_q;
	logic [47:0]        prev_t_q;
	logic               have_prev_q;
	logic [31:0]        cnt_q;
	logic signed [63:0] esum_q;
	logic [63:0]        sqsum_q;
	logic signed [31:0] cx_q, cy_q;
	logic signed [32:0] jx_q, jy_q;
	logic [31:0]        ax_q, ay_q;
	logic [63:0]        acc_q;     // dx^2 + dy^2, then variance
	logic [31:0]        d_q;       // distance
	logic [31:0]        sd_q;
	logic [31:0]        at_q;
	logic signed [31:0] err_q;
	logic signed [63:0] mean_q;
	logic [63:0]        ssn_q;
	logic               glitch_q;
	// square-root unit
	logic [63:0]        rv_q, rr_q, rb_q;
	// divider unit
	logic [63:0]        dq_q, drem_q;
	logic [6:0]         dcnt_q;
	logic               dneg_q;

	logic [63:0] rsum;
	logic [64:0] drem_sh;
	logic signed [48:0] tdiff;
	logic [48:0]  tabs;
	logic [31:0]  spd_abs;
	logic [31:0]  err_abs;
	logic [31:0]  mean_abs;
	logic [47:0]  travel;
	logic signed [49:0] errw;
	logic signed [31:0] errs;
	logic [63:0]  m2;
	logic signed [64:0] devw;
	logic [64:0]  dev;
	logic [39:0]  thr;
	logic [63:0]  esq;
	logic signed [64:0] esum_n;
	logic [64:0]  sqsum_n;
	logic signed [33:0] ox_n, oy_n;
	logic signed [31:0] oxs, oys;

	always_comb begin
		rsum = rr_q + rb_q;
		drem_sh = {drem_q, dq_q[63]};
		tdiff = $signed({1'b0, stamp_q}) - $signed({1'b0, prev_t_q});
		tabs = tdiff[48] ? 49'(-tdiff) : tdiff;
		spd_abs = spd_q[31] ? 32'(-spd_q) : 32'(spd_q);
		err_abs = err_q[31] ? 32'(-err_q) : 32'(err_q);
		mean_abs = mean_q[63] ? 32'(-mean_q) : 32'(mean_q);
		travel = 48'((64'(spd_abs) * 64'(at_q)) >> ojc_pkg::FRAC_BITS);
		errw = $signed({18'b0, d_q}) - $signed({2'b0, travel});
		if (errw > 50'sd2147483647) errs = 32'sh7fffffff;
		else if (errw < -50'sd2147483648) errs = 32'sh80000000;
		else errs = errw[31:0];
		m2 = 64'(mean_abs) * 64'(mean_abs);
		devw = 65'(err_q) - 65'(mean_q);
		dev = devw[64] ? 65'(-devw) : 65'(devw);
		thr = 40'(sigma_limit) * 40'(sd_q);
		esq = 64'(err_abs) * 64'(err_abs);
		esum_n = 65'(esum_q) + 65'(err_q);
		sqsum_n = 65'(sqsum_q) + 65'(esq);
		ox_n = 34'(off_x_q) + 34'(jx_q);
		oy_n = 34'(off_y_q) + 34'(jy_q);
		oxs = ojc_pkg::sat32(ox_n);
		oys = ojc_pkg::sat32(oy_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= '0; off_y_q <= '0; prev_x_q <= '0; prev_y_q <= '0;
			prev_t_q <= '0; have_prev_q <= 1'b0; cnt_q <= '0;
			esum_q <= '0; sqsum_q <= '0;
		end else begin
			unique case (cmd.op)
				ojc_pkg::OP_TEST: begin
					if (dev > 65'(thr)) begin
						off_x_q <= oxs;
						off_y_q <= oys;
					end
				end
				ojc_pkg::OP_COMMIT: begin
					prev_x_q <= cx_q; prev_y_q <= cy_q;
					prev_t_q <= stamp_q; have_prev_q <= 1'b1;
					if (have_prev_q && d_q != 32'd0) begin
						if (esum_n[64] != esum_n[63])
							esum_q <= esum_n[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
						else esum_q <= esum_n[63:0];
						sqsum_q <= sqsum_n[64] ? '1 : sqsum_n[63:0];
						if (cnt_q != '1) cnt_q <= cnt_q + 32'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			ojc_pkg::OP_LOAD: begin
				px_q <= pos_x; py_q <= pos_y; spd_q <= speed; stamp_q <= stamp;
				cx_q <= ojc_pkg::sat32(34'(pos_x) - 34'(off_x_q));
				cy_q <= ojc_pkg::sat32(34'(pos_y) - 34'(off_y_q));
				glitch_q <= 1'b0;
				d_q <= '0;
			end
			ojc_pkg::OP_DIFF: begin
				jx_q <= 33'(cx_q) - 33'(prev_x_q);
				jy_q <= 33'(cy_q) - 33'(prev_y_q);
				ax_q <= 32'($unsigned(ojc_pkg::sat32(34'(cx_q) - 34'(prev_x_q)) < 0 ?
					-33'(ojc_pkg::sat32(34'(cx_q) - 34'(prev_x_q))) :
					33'(ojc_pkg::sat32(34'(cx_q) - 34'(prev_x_q)))));
				ay_q <= 32'($unsigned(ojc_pkg::sat32(34'(cy_q) - 34'(prev_y_q)) < 0 ?
					-33'(ojc_pkg::sat32(34'(cy_q) - 34'(prev_y_q))) :
					33'(ojc_pkg::sat32(34'(cy_q) - 34'(prev_y_q)))));
				at_q <= (tabs[48:32] != 17'd0) ? '1 : tabs[31:0];
			end
			ojc_pkg::OP_SQ_X: acc_q <= 64'(ax_q) * 64'(ax_q);
			ojc_pkg::OP_SQ_Y: acc_q <= acc_q + 64'(ay_q) * 64'(ay_q);
			ojc_pkg::OP_SQRT_INIT: begin
				rv_q <= acc_q; rr_q <= '0; rb_q <= 64'd1 << 62;
			end
			ojc_pkg::OP_SQRT_STEP: begin
				if (rb_q > rv_q && rr_q == '0) rb_q <= rb_q >> 2;
				else begin
					if (rv_q >= rsum) begin
						rv_q <= rv_q - rsum;
						rr_q <= (rr_q >> 1) + rb_q;
					end else rr_q <= rr_q >> 1;
					rb_q <= rb_q >> 2;
				end
				if (rb_q[1:0] != 2'd0 || rb_q == '0) begin
					if (cmd.sel_var) sd_q <= (rv_q >= rsum) ? 32'((rr_q >> 1) + rb_q)
						: 32'(rr_q >> 1);
					else d_q <= (rv_q >= rsum) ? 32'((rr_q >> 1) + rb_q) : 32'(rr_q >> 1);
				end
			end
			ojc_pkg::OP_TRAVEL: err_q <= errs;
			ojc_pkg::OP_DIV_INIT: begin
				dcnt_q <= 7'd64; drem_q <= '0;
				if (cmd.sel_sq) begin dq_q <= sqsum_q; dneg_q <= 1'b0; end
				else begin
					dq_q <= esum_q[63] ? 64'(-esum_q) : 64'(esum_q);
					dneg_q <= esum_q[63];
				end
			end
			ojc_pkg::OP_DIV_STEP: begin
				if (dcnt_q != 7'd0) begin
					dcnt_q <= dcnt_q - 7'd1;
					if (drem_sh >= 65'(cnt_q)) begin
						drem_q <= 64'(drem_sh - 65'(cnt_q));
						dq_q <= {dq_q[62:0], 1'b1};
					end else begin
						drem_q <= drem_sh[63:0];
						dq_q <= {dq_q[62:0], 1'b0};
					end
				end else begin
					if (cmd.sel_sq) ssn_q <= dq_q;
					else mean_q <= dneg_q ? -$signed(dq_q) : $signed(dq_q);
				end
			end
			ojc_pkg::OP_VAR: acc_q <= (ssn_q > m2) ? ssn_q - m2 : '0;
			ojc_pkg::OP_TEST: begin
				if (dev > 65'(thr)) begin
					glitch_q <= 1'b1;
					err_q <= '0;
					cx_q <= ojc_pkg::sat32(34'(px_q) - 34'(oxs));
					cy_q <= ojc_pkg::sat32(34'(py_q) - 34'(oys));
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		sts.have_prev = have_prev_q;
		sts.moving = d_q != 32'd0;
		sts.test_on = cnt_q > 32'(min_samples);
		sts.var_pos = acc_q != 64'd0;
		sts.step_done = (cmd.op == ojc_pkg::OP_SQRT_STEP) ? (rb_q[1:0] != 2'd0 || rb_q == '0)
			: (dcnt_q == 7'd0);
	end

	assign res_x = cx_q;
	assign res_y = cy_q;
	assign res_glitch = glitch_q;
endmodule

@@ rtl/ojc_ctrl.sv @@
// Controller: sequences the datapath for one sample and holds the result.
module ojc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output ojc_pkg::cmd_t cmd,
	input  ojc_pkg::sts_t sts
);
	localparam logic [3:0] S_IDLE = 4'd0, S_DIFF = 4'd1, S_SQX = 4'd2, S_SQY = 4'd3,
		S_RTI = 4'd4, S_RT = 4'd5, S_TRV = 4'd6, S_D1I = 4'd7, S_D1 = 4'd8,
		S_D2I = 4'd9, S_D2 = 4'd10, S_VAR = 4'd11, S_VRI = 4'd12, S_VR = 4'd13,
		S_TEST = 4'd14, S_COMMIT = 4'd15;
	logic [3:0] state_q, state_n;
	logic       busy_q;

	assign in_ready = (state_q == S_IDLE) && !out_valid;

	always_comb begin
		state_n = state_q;
		cmd = '{op: ojc_pkg::OP_NONE, sel_var: 1'b0, sel_sq: 1'b0};
		unique case (state_q)
			S_IDLE: if (in_valid && in_ready) begin
				cmd.op = ojc_pkg::OP_LOAD; state_n = S_DIFF;
			end
			S_DIFF: begin
				cmd.op = ojc_pkg::OP_DIFF;
				state_n = sts.have_prev ? S_SQX : S_COMMIT;
			end
			S_SQX: begin cmd.op = ojc_pkg::OP_SQ_X; state_n = S_SQY; end
			S_SQY: begin cmd.op = ojc_pkg::OP_SQ_Y; state_n = S_RTI; end
			S_RTI: begin cmd.op = ojc_pkg::OP_SQRT_INIT; state_n = S_RT; end
			S_RT: begin
				cmd.op = ojc_pkg::OP_SQRT_STEP;
				if (sts.step_done) state_n = S_TRV;
			end
			S_TRV: begin
				cmd.op = ojc_pkg::OP_TRAVEL;
				state_n = (sts.moving && sts.test_on) ? S_D1I : S_COMMIT;
			end
			S_D1I: begin cmd.op = ojc_pkg::OP_DIV_INIT; state_n = S_D1; end
			S_D1: begin
				cmd.op = ojc_pkg::OP_DIV_STEP;
				if (sts.step_done) state_n = S_D2I;
			end
			S_D2I: begin cmd.op = ojc_pkg::OP_DIV_INIT; cmd.sel_sq = 1'b1; state_n = S_D2; end
			S_D2: begin
				cmd.op = ojc_pkg::OP_DIV_STEP; cmd.sel_sq = 1'b1;
				if (sts.step_done) state_n = S_VAR;
			end
			S_VAR: begin cmd.op = ojc_pkg::OP_VAR; state_n = S_VRI; end
			S_VRI: begin
				cmd.op = ojc_pkg::OP_SQRT_INIT;
				state_n = sts.var_pos ? S_VR : S_COMMIT;
			end
			S_VR: begin
				cmd.op = ojc_pkg::OP_SQRT_STEP; cmd.sel_var = 1'b1;
				if (sts.step_done) state_n = S_TEST;
			end
			S_TEST: begin cmd.op = ojc_pkg::OP_TEST; state_n = S_COMMIT; end
			S_COMMIT: begin cmd.op = ojc_pkg::OP_COMMIT; state_n = S_IDLE; end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == S_COMMIT) busy_q <= 1'b1;
			else if (out_ready) busy_q <= 1'b0;
		end
	end

	assign out_valid = busy_q;
endmodule

@@ rtl/odometry_jump_corrector.sv @@
// Top level: odometry jump corrector with APB register port.
// Usage:
// - Samples arrive on the in_ch sink (pos_x, pos_y, speed, stamp); a request
//   is taken when valid and ready are both high.
// - Each request yields one result on out_ch (out_x, out_y, glitch).
// - The block works on one sample at a time; in.ready is low from acceptance
//   until the result has been taken.
// - From acceptance to out.valid: the first sample is committed directly; any
//   other sample first takes a 32-step square root of the distance; a moving
//   sample with the outlier test enabled then takes two restoring divisions
//   (mean, mean square) and, unless the variance is zero, a second 32-step
//   square root and the outlier test.
// - The next sample is taken in the cycle after the result is taken at the
//   earliest, so the block never works on two samples at once.
// - When the receiver stalls, hold the result in the output register and
//   accept no new sample until it is taken.
// - Reset clears offsets, history, the error sums and the sample count and
//   restores min_samples to 100 and sigma_limit to 10.
// - Registers: min_samples at 0x0, sigma_limit at 0x4; write only while
//   idle. pready is always high.
module odometry_jump_corrector (
	input  logic        clk,
	input  logic        arst_n,
	ojc_in_if.sink      in_ch,
	ojc_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	ojc_pkg::cmd_t cmd;
	ojc_pkg::sts_t sts;
	logic [15:0] min_samples_q;
	logic [7:0]  sigma_limit_q;

	assign pready = 1'b1;

	// register writes at the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_samples_q <= ojc_pkg::MIN_SAMPLES_RESET;
			sigma_limit_q <= ojc_pkg::SIGMA_LIMIT_RESET;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
			if (paddr[2] == ojc_pkg::REG_MIN_SAMPLES) min_samples_q <= pwdata[15:0];
			else sigma_limit_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'd0) begin
			if (paddr[2] == ojc_pkg::REG_SIGMA_LIMIT) prdata = 32'(sigma_limit_q);
			else prdata = 32'(min_samples_q);
		end
	end

	ojc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cmd(cmd), .sts(sts)
	);

	ojc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.pos_x(in_ch.pos_x), .pos_y(in_ch.pos_y), .speed(in_ch.speed),
		.stamp(in_ch.stamp), .min_samples(min_samples_q), .sigma_limit(sigma_limit_q),
		.res_x(out_ch.out_x), .res_y(out_ch.out_y), .res_glitch(out_ch.glitch)
	);
endmodule

@@ tb/ojc_checker.sv @@
// Checker: watches the sample and result channels, predicts corrected positions and compares.
`timescale 1ns / 1ps
module ojc_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [31:0] cfg_val,
	ojc_in_if           in_mon,
	ojc_out_if          out_mon,
	output int          fail_count,
	output int          pending,
	output int          glitch_seen
);
	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic               g;
	} fix_t;

	fix_t fix_q[$];
	logic [15:0] min_samp;
	logic [7:0]  sig_lim;
	longint off_x, off_y, last_x, last_y;
	longint unsigned last_t;
	bit     seen;
	int unsigned moves;
	longint err_acc;
	longint unsigned sq_acc;

	assign pending = fix_q.size();

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint unsigned mag(longint v);
		return v < 0 ? 64'd0 - longint'(v) : v;
	endfunction

	function automatic longint unsigned root(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Advance the predictor by one sample and return the expected fix.
	function automatic fix_t correct(longint px, longint py, longint spd, longint unsigned st);
		fix_t f;
		longint cx, cy, jx, jy, t, err, mean;
		longint unsigned ax, ay, d, at, trav, am, ssn, m2, vr, sq;
		cx = clamp32(px - off_x);
		cy = clamp32(py - off_y);
		f.g = 1'b0;
		if (seen) begin
			jx = cx - last_x;
			jy = cy - last_y;
			ax = mag(clamp32(jx));
			ay = mag(clamp32(jy));
			d = root(ax * ax + ay * ay);
			t = longint'(st) - longint'(last_t);
			at = mag(t);
			if (at > 64'hFFFF_FFFF) at = 64'hFFFF_FFFF;
			trav = (mag(spd) * at) >> ojc_pkg::FRAC_BITS;
			err = clamp32(longint'(d) - longint'(trav));
			if (d > 0) begin
				if (moves > min_samp) begin
					mean = err_acc / longint'(moves);
					am = mag(mean);
					ssn = sq_acc / moves;
					m2 = am * am;
					vr = ssn > m2 ? ssn - m2 : 0;
					if (vr > 0 && mag(err - mean) > sig_lim * root(vr)) begin
						// jump: fold it into the offset and hold the last position
						f.g = 1'b1;
						off_x = clamp32(off_x + jx);
						off_y = clamp32(off_y + jy);
						cx = clamp32(px - off_x);
						cy = clamp32(py - off_y);
						err = 0;
					end
				end
				if (err > 0 && err_acc > 64'sh7FFF_FFFF_FFFF_FFFF - err)
					err_acc = 64'sh7FFF_FFFF_FFFF_FFFF;
				else if (err < 0 && err_acc < 64'sh8000_0000_0000_0000 - err)
					err_acc = 64'sh8000_0000_0000_0000;
				else
					err_acc += err;
				sq = mag(err) * mag(err);
				if (sq_acc > ~64'd0 - sq) sq_acc = ~64'd0;
				else sq_acc += sq;
				if (moves != 32'hFFFF_FFFF) moves++;
			end
		end
		last_x = cx;
		last_y = cy;
		last_t = st;
		seen = 1'b1;
		f.x = cx[31:0];
		f.y = cy[31:0];
		return f;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fix_t e;
		if (!arst_n) begin
			fix_q.delete();
			min_samp = ojc_pkg::MIN_SAMPLES_RESET;
			sig_lim = ojc_pkg::SIGMA_LIMIT_RESET;
			off_x = 0; off_y = 0; last_x = 0; last_y = 0; last_t = 0;
			seen = 0; moves = 0; err_acc = 0; sq_acc = 0;
			fail_count <= 0;
			glitch_seen <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == ojc_pkg::REG_MIN_SAMPLES) min_samp = cfg_val[15:0];
				else sig_lim = cfg_val[7:0];
			end
			if (out_mon.valid && out_mon.ready) begin
				if (fix_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10) $display("unexpected result x=%h y=%h g=%b",
						out_mon.out_x, out_mon.out_y, out_mon.glitch);
				end else begin
					e = fix_q.pop_front();
					if (e.g) glitch_seen <= glitch_seen + 1;
					if (e.x !== out_mon.out_x || e.y !== out_mon.out_y
							|| e.g !== out_mon.glitch) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("mismatch exp x=%h y=%h g=%b got x=%h y=%h g=%b",
								e.x, e.y, e.g, out_mon.out_x, out_mon.out_y,
								out_mon.glitch);
					end
				end
			end
			if (in_mon.valid && in_mon.ready)
				fix_q.push_back(correct(in_mon.pos_x, in_mon.pos_y, in_mon.speed,
					in_mon.stamp));
		end
	end
endmodule

@@ tb/odometry_jump_corrector_tb.sv @@
// Testbench top: drives samples and register writes, and reports the verdict.
`timescale 1ns / 1ps
module odometry_jump_corrector_tb;
	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0]  paddr = 0;
	logic [31:0] pwdata = 0;
	logic [31:0] prdata;
	logic        pready;
	int fail_count, pending, glitch_seen;
	int cycles = 0;
	int sent = 0;
	bit calm = 0;   // stretch with no idling on either side
	logic        cfg_we;
	logic        cfg_idx;

	ojc_in_if  in_ch (clk);
	ojc_out_if out_ch (clk);

	odometry_jump_corrector u_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// A register lands at the edge that completes the access phase.
	assign cfg_we = psel && penable && pwrite && pready;
	assign cfg_idx = paddr[2];

	ojc_checker u_chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_val(pwdata), .in_mon(in_ch), .out_mon(out_ch),
		.fail_count(fail_count), .pending(pending), .glitch_seen(glitch_seen)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1500000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Receiver: stall about 31 percent of cycles except in calm stretches.
	initial out_ch.ready = 0;
	always @(posedge clk) out_ch.ready <= calm || ($urandom_range(99) >= 31);

	initial begin
		in_ch.valid = 0;
		in_ch.pos_x = 0;
		in_ch.pos_y = 0;
		in_ch.speed = 0;
		in_ch.stamp = 0;
	end

	// Write one register in setup and access cycles.
	task automatic reg_write(logic reg_sel, logic [31:0] v);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1;
		paddr <= {reg_sel, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// Hold a request until taken, with random idle cycles before it.
	task automatic send(logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] s, logic [47:0] st);
		@(posedge clk);
		while (!calm && $urandom_range(99) < 31) @(posedge clk);
		in_ch.valid <= 1;
		in_ch.pos_x <= x; in_ch.pos_y <= y; in_ch.speed <= s; in_ch.stamp <= st;
		do @(posedge clk); while (!in_ch.ready);
		in_ch.valid <= 0;
		sent++;
	endtask

	// Drain outstanding results, then let the block settle before a write.
	task automatic drain;
		while (pending != 0) @(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	// A track of smooth motion with random content and occasional jumps.
	task automatic track(int n, int jump_pct);
		logic signed [31:0] x, y, spd, step;
		logic [47:0] st;
		x = $urandom; y = $urandom;
		x = x >>> 4; y = y >>> 4;
		st = {$urandom, 16'h0};
		for (int i = 0; i < n; i++) begin
			spd = $urandom_range(32'h4_0000);
			if ($urandom_range(1)) spd = -spd;
			st = st + 48'($urandom_range(32'h2000, 32'h8000));
			step = $urandom_range(32'h800);
			if ($urandom_range(99) < jump_pct) step = step + ($urandom_range(32'h7F) << 16);
			else if ($urandom_range(9) == 0) step = 0;
			if ($urandom_range(1)) x = x + step; else y = y - step;
			if ($urandom_range(49) == 0)
				send($urandom, $urandom, $urandom, 48'({$urandom, $urandom}));
			else
				send(x, y, spd, st);
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// Directed: extremes, first sample, still samples, time going backwards.
		send(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 48'hFFFF_FFFF_FFFF);
		send(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 48'h0);
		send(32'sh80000000, 32'sh7fffffff, 32'sh0, 48'h1_0000);
		send(32'sh0, 32'sh0, 32'sh1_0000, 48'h0_8000);
		send(32'sh0, 32'sh0, -32'sh1_0000, 48'h0);
		send(32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 48'h8000_0000_0000);
		send(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 48'h5555_5555_5555);
		send(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 48'hAAAA_AAAA_AAAA);
		drain();

		// Test enabled quickly with zero sigma: any deviation of a moving sample is a jump while the variance is nonzero.
		reg_write(ojc_pkg::REG_MIN_SAMPLES, 32'd0);
		reg_write(ojc_pkg::REG_SIGMA_LIMIT, 32'd0);
		track(20, 10);
		drain();
		reg_write(ojc_pkg::REG_MIN_SAMPLES, 32'd3);
		reg_write(ojc_pkg::REG_SIGMA_LIMIT, 32'd2);
		calm = 1;
		track(150, 8);
		calm = 0;
		drain();
		reg_write(ojc_pkg::REG_SIGMA_LIMIT, 32'd255);
		reg_write(ojc_pkg::REG_MIN_SAMPLES, 32'd65535);
		track(150, 8);
		drain();
		reg_write(ojc_pkg::REG_MIN_SAMPLES, 32'd10);
		reg_write(ojc_pkg::REG_SIGMA_LIMIT, 32'd4);
		track(250, 6);
		drain();
		reg_write(ojc_pkg::REG_MIN_SAMPLES, 32'd100);
		reg_write(ojc_pkg::REG_SIGMA_LIMIT, 32'd1);
		track(230, 5);

		while (pending != 0) @(posedge clk);
		repeat (250) @(posedge clk);
		$display("Sent %0d samples over five register settings, %0d judged as jumps.",
			sent, glitch_seen);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

@@ filelist.f @@
rtl/ojc_pkg.sv
rtl/ojc_if.sv
rtl/ojc_datapath.sv
rtl/ojc_ctrl.sv
rtl/odometry_jump_corrector.sv
tb/ojc_checker.sv
tb/odometry_jump_corrector_tb.sv
